/* design/sample_packet_receiver_top_defines.svh */
// assertion macros for the receiver checker
`ifndef SAMPLE_PACKET_RECEIVER_TOP_DEFINES_SVH
`define SAMPLE_PACKET_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SPR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SPR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/spr_pkg.sv */
// types and constants shared by the sample packet receiver
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SELECT,
    PS_READ,
    PS_FOLD,
    PS_UNPACK
  } parse_state_e;

  typedef enum logic [1:0] {
    UN_IDLE,
    UN_HDR,
    UN_REC,
    UN_PUSH
  } unpack_state_e;

  typedef enum logic [1:0] {
    EV_SAMPLE,
    EV_ALIVE,
    EV_TIMEOUT
  } event_e;

  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_A = 8'h41;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_SEED    = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] SEED_RESET    = 16'h4450;

  localparam int unsigned SAMPLES_PER_PACKET = 8;
  localparam int unsigned BUFFER_ENTRIES     = 256;

  localparam logic [2:0] HDR_BYTES = 3'd6;
  localparam logic [2:0] REC_BYTES = 3'd7;

  typedef struct packed {
    event_e      ev;
    logic [15:0] sample_index;
    logic [7:0]  error_code;
    logic [15:0] delta_time;
    logic [15:0] adc_value;
    logic [15:0] dac_value;
    logic [31:0] dut_timestamp;
    logic        checksum_bad;
    logic        buffer_complete;
    logic        last;
  } result_t;

  typedef struct packed {
    logic start;
    logic bad;
  } unpack_ctl_t;

  typedef struct packed {
    logic done;
    logic close;
  } unpack_sts_t;

endpackage
`default_nettype wire

/* design/spr_unpack.sv */
// packet store and the sequencer that unpacks header and sample records
`timescale 1ns / 1ps
`default_nettype none
module spr_unpack #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wr_en_i,
  input  wire  [5:0]            wr_addr_i,
  input  wire  [7:0]            wr_data_i,
  input  spr_pkg::unpack_ctl_t  ctl_i,
  output logic                  rec_valid_o,
  input  wire                   rec_ready_i,
  output spr_pkg::result_t      rec_o,
  output spr_pkg::unpack_sts_t  sts_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);

  logic [7:0] mem [PACKET_BYTES];
  logic [7:0] mem_q;

  spr_pkg::unpack_state_e state_q, state_d;
  logic [5:0]  rd_addr_q, rd_addr_d;
  logic [2:0]  iss_cnt_q, iss_cnt_d;
  logic [2:0]  cap_cnt_q, cap_cnt_d;
  logic [2:0]  rec_k_q, rec_k_d;
  logic        rd_vld_q, rd_vld_d;
  logic        rd_zero_q, rd_zero_d;
  logic        bad_q, bad_d;
  logic [16:0] last_end_q, last_end_d;
  logic [47:0] hdr_q, hdr_d;
  logic [55:0] rec_q, rec_d;

  logic [2:0]  glen;
  logic        issue;
  logic        in_range;
  logic        group_done;
  logic [7:0]  cap_byte;
  logic [16:0] end_idx;
  logic        fin;
  logic        complete;

  // store writes while the packet streams in, reads while unpacking
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i[AW-1:0]] <= wr_data_i;
    end
    if (issue && in_range) begin
      mem_q <= mem[rd_addr_q[AW-1:0]];
    end
  end

  assign glen       = (state_q == spr_pkg::UN_HDR) ? spr_pkg::HDR_BYTES : spr_pkg::REC_BYTES;
  assign issue      = ((state_q == spr_pkg::UN_HDR) || (state_q == spr_pkg::UN_REC)) &&
                      (iss_cnt_q != glen);
  assign in_range   = {1'b0, rd_addr_q} < 7'(PACKET_BYTES);
  assign group_done = rd_vld_q && (cap_cnt_q == glen - 3'd1);
  // bytes past the end of the packet read as zero
  assign cap_byte   = rd_zero_q ? 8'h00 : mem_q;

  assign end_idx  = {1'b0, hdr_q[47:32]} + 17'(spr_pkg::SAMPLES_PER_PACKET);
  assign fin      = rec_k_q == 3'(spr_pkg::SAMPLES_PER_PACKET - 1);
  assign complete = (end_idx == 17'(spr_pkg::BUFFER_ENTRIES)) && (end_idx != last_end_q);

  always_comb begin
    rec_o.ev              = spr_pkg::EV_SAMPLE;
    rec_o.sample_index    = hdr_q[47:32] + {13'b0, rec_k_q};
    rec_o.error_code      = rec_q[55:48];
    rec_o.delta_time      = rec_q[47:32];
    rec_o.adc_value       = rec_q[31:16];
    rec_o.dac_value       = rec_q[15:0];
    rec_o.dut_timestamp   = hdr_q[31:0];
    rec_o.checksum_bad    = bad_q;
    rec_o.buffer_complete = fin && complete;
    rec_o.last            = fin;
  end

  always_comb begin
    state_d    = state_q;
    rd_addr_d  = rd_addr_q;
    iss_cnt_d  = iss_cnt_q;
    cap_cnt_d  = cap_cnt_q;
    rec_k_d    = rec_k_q;
    rd_vld_d   = 1'b0;
    rd_zero_d  = 1'b0;
    bad_d      = bad_q;
    last_end_d = last_end_q;
    hdr_d      = hdr_q;
    rec_d      = rec_q;
    rec_valid_o = 1'b0;
    sts_o      = '0;

    unique case (state_q) inside
      spr_pkg::UN_IDLE: begin
        if (ctl_i.start) begin
          bad_d     = ctl_i.bad;
          rd_addr_d = '0;
          iss_cnt_d = '0;
          cap_cnt_d = '0;
          rec_k_d   = '0;
          state_d   = spr_pkg::UN_HDR;
        end
      end
      spr_pkg::UN_HDR, spr_pkg::UN_REC: begin
        if (issue) begin
          rd_addr_d = rd_addr_q + 6'd1;
          iss_cnt_d = iss_cnt_q + 3'd1;
          rd_vld_d  = 1'b1;
          rd_zero_d = !in_range;
        end
        if (rd_vld_q) begin
          cap_cnt_d = cap_cnt_q + 3'd1;
          if (state_q == spr_pkg::UN_HDR) begin
            hdr_d = {hdr_q[39:0], cap_byte};
          end else begin
            rec_d = {rec_q[47:0], cap_byte};
          end
        end
        if (group_done) begin
          iss_cnt_d = '0;
          cap_cnt_d = '0;
          state_d   = (state_q == spr_pkg::UN_HDR) ? spr_pkg::UN_REC : spr_pkg::UN_PUSH;
        end
      end
      spr_pkg::UN_PUSH: begin
        rec_valid_o = 1'b1;
        if (rec_ready_i) begin
          rec_k_d = rec_k_q + 3'd1;
          if (fin) begin
            last_end_d = end_idx;
            sts_o.done  = 1'b1;
            sts_o.close = complete;
            state_d     = spr_pkg::UN_IDLE;
          end else begin
            state_d = spr_pkg::UN_REC;
          end
        end
      end
      default: begin
        state_d = spr_pkg::UN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spr_pkg::UN_IDLE;
      rd_addr_q  <= '0;
      iss_cnt_q  <= '0;
      cap_cnt_q  <= '0;
      rec_k_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_zero_q  <= 1'b0;
      bad_q      <= 1'b0;
      last_end_q <= '0;
    end else begin
      state_q    <= state_d;
      rd_addr_q  <= rd_addr_d;
      iss_cnt_q  <= iss_cnt_d;
      cap_cnt_q  <= cap_cnt_d;
      rec_k_q    <= rec_k_d;
      rd_vld_q   <= rd_vld_d;
      rd_zero_q  <= rd_zero_d;
      bad_q      <= bad_d;
      last_end_q <= last_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    rec_q <= rec_d;
  end

endmodule
`default_nettype wire

/* design/sample_packet_receiver_top.sv */
// sample packet receiver: sync parser, checksum, tick timeout and result queue
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  kind_i, data_byte_i
//   result    out        out_valid_o/out_stall_i event_res_o .. last_o
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// a byte or tick is taken outside fold and unpack when the two-entry queue has room
// after the last packet byte the input stalls while the parser folds and unpacks:
//   a checksum fold state, then the packet store is read one byte per cycle
//   through its single read port, plus one queue push per sample record
// records wait longer when the result side stalls and the queue is full
// reset clears the parser, counters and queue; the packet store holds no reset
`timescale 1ns / 1ps
`default_nettype none
module sample_packet_receiver_top #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         kind_i,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [15:0] sample_index_o,
  output logic [7:0]  error_code_o,
  output logic [15:0] delta_time_o,
  output logic [15:0] adc_value_o,
  output logic [15:0] dac_value_o,
  output logic [31:0] dut_timestamp_o,
  output logic        checksum_bad_o,
  output logic        buffer_complete_o,
  output logic        last_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  spr_pkg::parse_state_e ps_q, ps_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [23:0] acc_q, acc_d;
  logic        open_q, open_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] timeout_q;
  logic [15:0] seed_q;

  logic        in_acc;
  logic        cfg_wr;
  logic [15:0] tick_inc;
  logic [15:0] fold_sum;
  logic [23:0] add_val;

  logic             evt_push;
  spr_pkg::result_t evt_res;
  logic             wr_en;
  spr_pkg::unpack_ctl_t ctl;
  spr_pkg::unpack_sts_t sts;
  logic             rec_valid;
  spr_pkg::result_t rec;

  spr_pkg::result_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       full;
  logic       push;
  logic       pop;
  spr_pkg::result_t push_data;
  spr_pkg::result_t head;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == spr_pkg::REG_SEED) ? {16'b0, seed_q} : {16'b0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= spr_pkg::TIMEOUT_RESET;
      seed_q    <= spr_pkg::SEED_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == spr_pkg::REG_SEED) begin
        seed_q <= pwdata[15:0];
      end else begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  assign full       = count_q == 2'd2;
  assign in_stall_o = (ps_q == spr_pkg::PS_FOLD) || (ps_q == spr_pkg::PS_UNPACK) || full;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  // end-around carry folds only bits 19..16 back in
  assign fold_sum = acc_q[15:0] + {12'b0, acc_q[19:16]};
  assign add_val  = cnt_q[0] ? {16'b0, data_byte_i} : {8'b0, data_byte_i, 8'b0};

  always_comb begin
    ps_d     = ps_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    open_d   = open_q;
    tick_d   = tick_q;
    evt_push = 1'b0;
    evt_res  = '0;
    evt_res.last = 1'b1;
    wr_en    = 1'b0;
    ctl      = '0;

    if (in_acc) begin
      if (kind_i) begin
        if (open_q) begin
          tick_d = tick_inc;
          if (tick_inc > timeout_q) begin
            open_d     = 1'b0;
            ps_d       = spr_pkg::PS_IDLE;
            cnt_d      = '0;
            evt_push   = 1'b1;
            evt_res.ev = spr_pkg::EV_TIMEOUT;
          end
        end
      end else begin
        unique case (ps_q)
          spr_pkg::PS_SELECT: begin
            if (data_byte_i == spr_pkg::CHAR_P) begin
              open_d = 1'b1;
              tick_d = '0;
              acc_d  = {8'b0, seed_q};
              cnt_d  = '0;
              ps_d   = spr_pkg::PS_READ;
            end else if (data_byte_i == spr_pkg::CHAR_A) begin
              open_d     = 1'b0;
              ps_d       = spr_pkg::PS_IDLE;
              evt_push   = 1'b1;
              evt_res.ev = spr_pkg::EV_ALIVE;
            end else if (data_byte_i != spr_pkg::CHAR_D) begin
              ps_d = spr_pkg::PS_IDLE;
            end
          end
          spr_pkg::PS_READ: begin
            acc_d = acc_q + add_val;
            wr_en = 1'b1;
            if (cnt_q == 6'(PACKET_BYTES - 1)) begin
              cnt_d = '0;
              ps_d  = spr_pkg::PS_FOLD;
            end else begin
              cnt_d = cnt_q + 6'd1;
            end
          end
          default: begin
            cnt_d = '0;
            ps_d  = (data_byte_i == spr_pkg::CHAR_D) ? spr_pkg::PS_SELECT : spr_pkg::PS_IDLE;
          end
        endcase
      end
    end

    if (ps_q == spr_pkg::PS_FOLD) begin
      ctl.start = 1'b1;
      ctl.bad   = fold_sum != 16'hFFFF;
      ps_d      = spr_pkg::PS_UNPACK;
    end
    if ((ps_q == spr_pkg::PS_UNPACK) && sts.done) begin
      ps_d = spr_pkg::PS_IDLE;
      if (sts.close) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= spr_pkg::PS_IDLE;
      cnt_q  <= '0;
      acc_q  <= '0;
      open_q <= 1'b0;
      tick_q <= '0;
    end else begin
      ps_q   <= ps_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      open_q <= open_d;
      tick_q <= tick_d;
    end
  end

  spr_unpack #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (cnt_q),
    .wr_data_i   (data_byte_i),
    .ctl_i       (ctl),
    .rec_valid_o (rec_valid),
    .rec_ready_i (!full),
    .rec_o       (rec),
    .sts_o       (sts)
  );

  // two-entry result queue decouples record bursts from the result side
  assign push      = evt_push || (rec_valid && !full);
  assign push_data = evt_push ? evt_res : rec;
  assign pop       = out_valid_o && !out_stall_i;
  assign head      = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid_o       = count_q != 2'd0;
  assign event_res_o       = head.ev;
  assign sample_index_o    = head.sample_index;
  assign error_code_o      = head.error_code;
  assign delta_time_o      = head.delta_time;
  assign adc_value_o       = head.adc_value;
  assign dac_value_o       = head.dac_value;
  assign dut_timestamp_o   = head.dut_timestamp;
  assign checksum_bad_o    = head.checksum_bad;
  assign buffer_complete_o = head.buffer_complete;
  assign last_o            = head.last;

endmodule
`default_nettype wire

/* design/spr_checker.sv */
// port-level checks on the receiver result channel
`timescale 1ns / 1ps
`default_nettype none
`include "sample_packet_receiver_top_defines.svh"
module spr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  event_res_o,
  input wire [15:0] sample_index_o,
  input wire [31:0] dut_timestamp_o,
  input wire        checksum_bad_o,
  input wire        buffer_complete_o,
  input wire        last_o
);

  `SPR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(event_res_o) && $stable(sample_index_o) && $stable(dut_timestamp_o) && $stable(last_o), "stalled result transaction changed")
  `SPR_ASSERT_IMP(a_event_clean, clk_i, rst_ni, out_valid_o && (event_res_o != spr_pkg::EV_SAMPLE), last_o && !buffer_complete_o && !checksum_bad_o && (sample_index_o == 16'd0) && (dut_timestamp_o == 32'd0), "alive or timeout result carries sample data")
  `SPR_ASSERT_IMP(a_complete_last, clk_i, rst_ni, out_valid_o && buffer_complete_o, last_o && (event_res_o == spr_pkg::EV_SAMPLE), "buffer complete outside the final record")

endmodule

bind sample_packet_receiver_top spr_checker u_spr_checker (.*);
`default_nettype wire

/* tb/sample_packet_receiver_top_tb.sv */
// self-checking testbench for the sample packet receiver: deframing, checksum, timeouts
`timescale 1ns / 1ps
module sample_packet_receiver_top_tb;

  localparam int unsigned PKT_BYTES        = 64;
  localparam int unsigned CLK_HALF         = 5;
  localparam int unsigned RESET_CYCLES     = 12;
  localparam int unsigned DRAIN_CYCLES     = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 500;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned MAX_REPORTS      = 200;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_res_o;
  logic [15:0] sample_index_o;
  logic [7:0]  error_code_o;
  logic [15:0] delta_time_o;
  logic [15:0] adc_value_o;
  logic [15:0] dac_value_o;
  logic [31:0] dut_timestamp_o;
  logic        checksum_bad_o;
  logic        buffer_complete_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sample_packet_receiver_top #(
    .PACKET_BYTES(PKT_BYTES)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .kind_i(kind_i), .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .event_res_o(event_res_o), .sample_index_o(sample_index_o),
    .error_code_o(error_code_o), .delta_time_o(delta_time_o),
    .adc_value_o(adc_value_o), .dac_value_o(dac_value_o),
    .dut_timestamp_o(dut_timestamp_o), .checksum_bad_o(checksum_bad_o),
    .buffer_complete_o(buffer_complete_o), .last_o(last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // mirror of the deframer state and its registers
  logic [15:0]           cfg_timeout = spr_pkg::TIMEOUT_RESET;
  logic [15:0]           cfg_seed    = spr_pkg::SEED_RESET;
  spr_pkg::parse_state_e m_state     = spr_pkg::PS_IDLE;
  logic [5:0]            m_count     = '0;
  logic [23:0]           m_sum       = '0;
  logic [7:0]            m_store [PKT_BYTES];
  logic [16:0]           m_last_end  = '0;
  bit                    m_open      = 1'b0;
  logic [15:0]           m_ticks     = '0;

  spr_pkg::result_t pending_results [$];
  int unsigned  error_count   = 0;
  int unsigned  results_seen  = 0;
  int unsigned  bytes_sent    = 0;
  int unsigned  cycle_count   = 0;
  bit           sender_gaps_on = 1'b1;
  bit           hold_armed     = 1'b0;
  bit           hold_active    = 1'b0;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 24) == 0) return $urandom_range(12, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // biased toward the sync and command characters
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 5))
      0: return spr_pkg::CHAR_D;
      1: return spr_pkg::CHAR_P;
      2: return spr_pkg::CHAR_A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic deframe_item(input logic kind, input logic [7:0] b);
    spr_pkg::result_t r;
    logic [27:0] folded;
    logic [16:0] end_idx;
    logic [15:0] offset;
    bit          complete;
    int          base;
    r = '0;
    if (kind == KIND_TICK) begin
      if (!m_open) return;
      if (m_ticks != 16'hFFFF) m_ticks = m_ticks + 1'b1;
      if (m_ticks > cfg_timeout) begin
        m_open  = 1'b0;
        m_state = spr_pkg::PS_IDLE;
        m_count = '0;
        r.ev    = spr_pkg::EV_TIMEOUT;
        r.last  = 1'b1;
        pending_results.push_back(r);
      end
      return;
    end
    case (m_state)
      spr_pkg::PS_SELECT: begin
        if (b == spr_pkg::CHAR_P) begin
          m_open  = 1'b1;
          m_ticks = '0;
          m_sum   = {8'b0, cfg_seed};
          m_count = '0;
          m_state = spr_pkg::PS_READ;
        end else if (b == spr_pkg::CHAR_A) begin
          m_open  = 1'b0;
          m_state = spr_pkg::PS_IDLE;
          r.ev    = spr_pkg::EV_ALIVE;
          r.last  = 1'b1;
          pending_results.push_back(r);
        end else if (b != spr_pkg::CHAR_D) begin
          m_state = spr_pkg::PS_IDLE;
        end
      end
      spr_pkg::PS_READ: begin
        // big-endian words: even bytes are the high half
        m_sum = m_sum + (m_count[0] ? {16'b0, b} : {8'b0, b, 8'b0});
        m_store[m_count] = b;
        if (m_count != 6'(PKT_BYTES - 1)) begin
          m_count = m_count + 1'b1;
        end else begin
          m_state = spr_pkg::PS_IDLE;
          m_count = '0;
          // only four carry bits fold back into the sum
          folded   = {4'b0, m_sum} + {24'b0, m_sum[19:16]};
          offset   = {m_store[0], m_store[1]};
          end_idx  = {1'b0, offset} + 17'(spr_pkg::SAMPLES_PER_PACKET);
          complete = (end_idx == 17'(spr_pkg::BUFFER_ENTRIES)) && (end_idx != m_last_end);
          m_last_end = end_idx;
          for (int k = 0; k < spr_pkg::SAMPLES_PER_PACKET; k++) begin
            base = int'(spr_pkg::HDR_BYTES) + int'(spr_pkg::REC_BYTES) * k;
            r.ev              = spr_pkg::EV_SAMPLE;
            r.sample_index    = offset + 16'(k);
            r.error_code      = m_store[base];
            r.delta_time      = {m_store[base + 1], m_store[base + 2]};
            r.adc_value       = {m_store[base + 3], m_store[base + 4]};
            r.dac_value       = {m_store[base + 5], m_store[base + 6]};
            r.dut_timestamp   = {m_store[2], m_store[3], m_store[4], m_store[5]};
            r.checksum_bad    = (folded[15:0] != 16'hFFFF);
            r.last            = (k == spr_pkg::SAMPLES_PER_PACKET - 1);
            r.buffer_complete = complete && r.last;
            pending_results.push_back(r);
          end
          if (complete) m_open = 1'b0;
        end
      end
      default: begin
        m_count = '0;
        m_state = (b == spr_pkg::CHAR_D) ? spr_pkg::PS_SELECT : spr_pkg::PS_IDLE;
      end
    endcase
  endtask

  // valid stays high from one transaction to the next unless a gap is drawn
  task automatic send_item(input logic kind, input logic [7:0] b);
    int unsigned gap;
    gap = sender_gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_item(kind, b);
    if (kind == KIND_BYTE) bytes_sent++;
  endtask

  task automatic send_packet(input logic [15:0] offset, input fill_e fill, input bit good,
                             input int unsigned tick_permille);
    logic [7:0]  pkt [PKT_BYTES];
    logic [23:0] acc;
    logic [23:0] t;
    logic [15:0] w;
    for (int i = 0; i < PKT_BYTES; i++) begin
      case (fill)
        FILL_ZERO: pkt[i] = 8'h00;
        FILL_ONES: pkt[i] = 8'hFF;
        default:   pkt[i] = 8'($urandom_range(0, 255));
      endcase
    end
    pkt[0] = offset[15:8];
    pkt[1] = offset[7:0];
    if (good) begin
      // the closing word is not decoded, so it carries the checksum fix
      acc = {8'b0, cfg_seed};
      for (int i = 0; i < PKT_BYTES - 2; i += 2) acc = acc + {8'b0, pkt[i], pkt[i + 1]};
      for (int c = 0; c < 16; c++) begin
        w = 16'hFFFF - 16'(c) - acc[15:0];
        t = acc + {8'b0, w};
        if (((t + {20'b0, t[19:16]}) & 24'hFFFF) == 24'hFFFF) begin
          pkt[PKT_BYTES - 2] = w[15:8];
          pkt[PKT_BYTES - 1] = w[7:0];
          break;
        end
      end
    end
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_P);
    for (int i = 0; i < PKT_BYTES; i++) begin
      if ($urandom_range(0, 999) < tick_permille) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, pkt[i]);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == spr_pkg::REG_TIMEOUT) cfg_timeout = value;
    else cfg_seed = value;
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_checker
    spr_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction waiting for it");
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 32'(event_res_o), 32'(want.ev));
        check_field("sample_index", 32'(sample_index_o), 32'(want.sample_index));
        check_field("error_code", 32'(error_code_o), 32'(want.error_code));
        check_field("delta_time", 32'(delta_time_o), 32'(want.delta_time));
        check_field("adc_value", 32'(adc_value_o), 32'(want.adc_value));
        check_field("dac_value", 32'(dac_value_o), 32'(want.dac_value));
        check_field("dut_timestamp", dut_timestamp_o, want.dut_timestamp);
        check_field("checksum_bad", 32'(checksum_bad_o), 32'(want.checksum_bad));
        check_field("buffer_complete", 32'(buffer_complete_o), 32'(want.buffer_complete));
        check_field("last", 32'(last_o), 32'(want.last));
      end
      results_seen++;
    end
  end

  initial begin : result_stall_gen
    int unsigned n;
    @(posedge clk_i);
    forever begin
      if (hold_armed) begin
        hold_armed  = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 39) == 0) ? 150 : 1 + gap_len();
      repeat (n) @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic test_sync_and_alive();
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    // repeated sync bytes keep the select state
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    // out of sync: any other byte drops back to idle
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    send_item(KIND_BYTE, spr_pkg::CHAR_P);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    // ticks with no packet open are ignored
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
  endtask

  task automatic test_packet_fields();
    // fills the buffer, then the same end index again is not a completion
    send_packet(16'(spr_pkg::BUFFER_ENTRIES - spr_pkg::SAMPLES_PER_PACKET),
                FILL_RANDOM, 1'b1, 0);
    send_packet(16'(spr_pkg::BUFFER_ENTRIES - spr_pkg::SAMPLES_PER_PACKET),
                FILL_ONES, 1'b0, 0);
  endtask

  task automatic test_timeouts();
    wait_idle();
    write_reg(spr_pkg::REG_TIMEOUT, 16'd0);
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_P);
    repeat (5) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    wait_idle();
    // a packet that leaves the buffer incomplete stays open and can still expire
    write_reg(spr_pkg::REG_TIMEOUT, 16'd2);
    send_packet(16'd100, FILL_RANDOM, 1'b1, 0);
    repeat (4) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_alive_closes_packet();
    wait_idle();
    write_reg(spr_pkg::REG_TIMEOUT, 16'd1);
    send_packet(16'd7, FILL_RANDOM, 1'b1, 0);
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    repeat (3) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_result_backpressure();
    wait_idle();
    write_reg(spr_pkg::REG_TIMEOUT, 16'hFFFF);
    sender_gaps_on = 1'b0;
    hold_armed = 1'b1;
    // the long hold is already running when the records come out
    while (!hold_active) @(posedge clk_i);
    send_packet(16'($urandom_range(0, 65535)), FILL_RANDOM, 1'b1, 0);
    send_item(KIND_BYTE, spr_pkg::CHAR_D);
    send_item(KIND_BYTE, spr_pkg::CHAR_A);
    repeat (2) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    sender_gaps_on = 1'b1;
  endtask

  task automatic run_random_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned pick;
    logic [15:0] offset;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 9)) inside
          [0:2]:   offset = 16'(spr_pkg::BUFFER_ENTRIES - spr_pkg::SAMPLES_PER_PACKET);
          3:       offset = 16'hFFFF;
          4:       offset = 16'hFFF8;
          5:       offset = 16'h0000;
          default: offset = 16'($urandom_range(0, 65535));
        endcase
        send_packet(offset, FILL_RANDOM, $urandom_range(0, 4) != 0, $urandom_range(0, 20));
      end else if (pick < 67) begin
        send_item(KIND_BYTE, spr_pkg::CHAR_D);
        send_item(KIND_BYTE, spr_pkg::CHAR_A);
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 12)) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 6)) send_item(KIND_BYTE, random_byte());
      end else if (pick < 95) begin
        // truncated packet, the bytes that follow are read as its payload
        send_item(KIND_BYTE, spr_pkg::CHAR_D);
        send_item(KIND_BYTE, spr_pkg::CHAR_P);
        repeat ($urandom_range(1, PKT_BYTES - 1)) send_item(KIND_BYTE, random_byte());
      end else begin
        repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, spr_pkg::CHAR_D);
        send_item(KIND_BYTE, random_byte());
      end
    end
  endtask

  task automatic test_random_settings();
    logic [15:0] timeouts [3];
    logic [15:0] seeds [3];
    timeouts = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 30))};
    seeds    = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535))};
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      write_reg(spr_pkg::REG_TIMEOUT, timeouts[p]);
      write_reg(spr_pkg::REG_SEED, seeds[p]);
      run_random_traffic(16);
    end
  endtask

  initial begin : main
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sync_and_alive();
    test_packet_fields();
    test_timeouts();
    test_alive_closes_packet();
    test_result_backpressure();
    test_random_settings();
    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/spr_pkg.sv
design/spr_unpack.sv
design/sample_packet_receiver_top.sv
design/spr_checker.sv
tb/sample_packet_receiver_top_tb.sv
